// ----- sv/mm3_pkg.sv -----
package mm3_pkg;

    // Hash word width
    localparam int HASH_W = 32;

    // Mixing constants of the x86_32 variant
    localparam logic [HASH_W-1:0] MIX_C1     = 32'hcc9e2d51;
    localparam logic [HASH_W-1:0] MIX_C2     = 32'h1b873593;
    localparam logic [HASH_W-1:0] SEED_RESET = 32'h5a5a5a5a;
    localparam logic [HASH_W-1:0] ROUND_ADD  = 32'he6546b64;
    localparam logic [HASH_W-1:0] FIN_C1     = 32'h85ebca6b;
    localparam logic [HASH_W-1:0] FIN_C2     = 32'hc2b2ae35;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_TAKE,
        OP_MUL1,
        OP_TAIL1,
        OP_MUL2,
        OP_ROUND,
        OP_TAILXOR,
        OP_PLAINXOR,
        OP_FIN1,
        OP_FIN2,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic block_full;   // three bytes held in an open key
        logic tail_nonzero; // tail bytes wait to be mixed
        logic out_free;     // output register can take a result
    } t_dp_status;

endpackage

// ----- sv/murmur3_32bit_stream_hash.sv -----
// MurmurHash3 (x86_32) of a byte stream. Each input beat carries one key byte
// in tdata, tuser marks whether the byte belongs to the key, and tlast ends the
// key; a beat with tuser low and tlast high hashes the empty key, and one with
// both low is ignored. One 32-bit hash beat is produced per key. The seed
// register is sampled when the first beat of a key is accepted, so a seed
// write affects the next key. A byte that does not complete a 4-byte block
// leaves the input ready for another byte; after the byte completing a block
// the input is held off while the block goes twice through the single shared
// 32x32 multiplier (S_MIX1, S_MIX2) before the round update (S_ROUND). A beat
// with tlast adds finalization: 1 to 3 pending tail bytes are mixed through
// the same multiplier twice, then come the two avalanche multiplies on it, and
// the hash waits in S_EMIT while the previous hash still holds the output
// register. A new key may start while the previous hash still waits on the
// output; the key length wraps modulo 2^LENGTH_BITS.
module murmur3_32bit_stream_hash #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] key_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // key_end
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] hash_value
    // Seed register write
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    import mm3_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    mm3_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_has_byte (s_axis_tuser),
        .i_key_end  (s_axis_tlast),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mm3_datapath #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_key_byte  (s_axis_tdata),
        .i_has_byte  (s_axis_tuser),
        .i_key_end   (s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    // A result is only loaded when the output register is free.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_EMIT) |-> (!m_axis_tvalid || m_axis_tready))
        else $error("hash loaded into an occupied output register");

    // The byte completing a block keeps the block busy for the mix.
    a_block_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser && status.block_full)
        |=> (!s_axis_tready && cmd.op == OP_MUL1))
        else $error("full block not mixed after its last byte");

    // A key end is always followed by finalization.
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("key end accepted without finalization");

endmodule

// ----- sv/mm3_datapath.sv -----
module mm3_datapath #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  mm3_pkg::t_dp_cmd         i_cmd,
    output mm3_pkg::t_dp_status      o_status,
    input  logic [7:0]               i_key_byte,
    input  logic                     i_has_byte,
    input  logic                     i_key_end,
    input  logic                     i_cfg_we,
    input  logic [31:0]              i_cfg_wdata,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [31:0]              o_out_data
);
    import mm3_pkg::*;

    logic [HASH_W-1:0]      r_seed;
    logic [HASH_W-1:0]      r_hash, n_hash;
    logic [23:0]            r_part, n_part;
    logic [1:0]             r_phase, n_phase;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic                   r_open, n_open;
    logic [HASH_W-1:0]      r_acc, n_acc;
    logic [HASH_W-1:0]      r_out, n_out;
    logic                   r_out_valid;

    logic [HASH_W-1:0]      eff_hash;
    logic [23:0]            eff_part;
    logic [1:0]             eff_phase;
    logic [LENGTH_BITS-1:0] eff_len;
    logic [HASH_W-1:0]      mul_a, mul_b, mul_p;
    logic [HASH_W-1:0]      acc_rot15, round_x, round_rot13;
    logic [HASH_W-1:0]      len_ext;

    // A closed key starts from the seed and empty block state.
    assign eff_hash  = r_open ? r_hash  : r_seed;
    assign eff_part  = r_open ? r_part  : 24'd0;
    assign eff_phase = r_open ? r_phase : 2'd0;
    assign eff_len   = r_open ? r_len   : '0;

    assign acc_rot15   = {r_acc[16:0], r_acc[31:17]};
    assign round_x     = r_hash ^ r_acc;
    assign round_rot13 = {round_x[18:0], round_x[31:19]};
    assign len_ext     = HASH_W'(r_len);

    // Shared multiplier: operand selection by operation, low word kept.
    always_comb begin
        mul_a = r_acc;
        mul_b = MIX_C1;
        case (i_cmd.op)
            OP_TAIL1: begin
                mul_a = HASH_W'(r_part);
            end
            OP_MUL2: begin
                mul_a = acc_rot15;
                mul_b = MIX_C2;
            end
            OP_FIN1: begin
                mul_a = r_acc ^ (r_acc >> 16);
                mul_b = FIN_C1;
            end
            OP_FIN2: begin
                mul_a = r_acc ^ (r_acc >> 13);
                mul_b = FIN_C2;
            end
            default: begin
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Next-state logic of the hash state.
    always_comb begin
        n_hash  = r_hash;
        n_part  = r_part;
        n_phase = r_phase;
        n_len   = r_len;
        n_open  = r_open;
        n_acc   = r_acc;
        n_out   = r_out;
        unique case (i_cmd.op)
            OP_TAKE: begin
                if (i_has_byte || i_key_end) begin
                    n_hash  = eff_hash;
                    n_part  = eff_part;
                    n_phase = eff_phase;
                    n_len   = eff_len;
                    n_open  = 1'b1;
                end
                if (i_has_byte) begin
                    n_len = eff_len + LENGTH_BITS'(1);
                    if (eff_phase == 2'd3) begin
                        n_acc = {i_key_byte, eff_part};
                    end else begin
                        case (eff_phase)
                            2'd0:    n_part[7:0]   = i_key_byte;
                            2'd1:    n_part[15:8]  = i_key_byte;
                            default: n_part[23:16] = i_key_byte;
                        endcase
                        n_phase = eff_phase + 2'd1;
                    end
                end
            end
            OP_MUL1, OP_TAIL1, OP_MUL2, OP_FIN1, OP_FIN2: begin
                n_acc = mul_p;
            end
            OP_ROUND: begin
                n_hash  = (round_rot13 << 2) + round_rot13 + ROUND_ADD;
                n_part  = 24'd0;
                n_phase = 2'd0;
            end
            OP_TAILXOR: begin
                n_acc = r_hash ^ r_acc ^ len_ext;
            end
            OP_PLAINXOR: begin
                n_acc = r_hash ^ len_ext;
            end
            OP_EMIT: begin
                n_out  = r_acc ^ (r_acc >> 16);
                n_open = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // State registers, seed register and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= SEED_RESET;
            r_part      <= 24'd0;
            r_phase     <= 2'd0;
            r_len       <= '0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            r_part  <= n_part;
            r_phase <= n_phase;
            r_len   <= n_len;
            r_open  <= n_open;
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_hash <= n_hash;
        r_acc  <= n_acc;
        r_out  <= n_out;
    end

    assign o_status.block_full   = r_open && (r_phase == 2'd3);
    assign o_status.tail_nonzero = (r_phase != 2'd0);
    assign o_status.out_free     = !r_out_valid || i_out_ready;
    assign o_out_valid           = r_out_valid;
    assign o_out_data            = r_out;

endmodule

// ----- sv/mm3_ctrl.sv -----
module mm3_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_has_byte,
    input  logic                i_key_end,
    input  mm3_pkg::t_dp_status i_status,
    output mm3_pkg::t_dp_cmd    o_cmd
);
    import mm3_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIX1,
        S_MIX2,
        S_ROUND,
        S_FIN_SEL,
        S_TAIL2,
        S_TAIL3,
        S_FIN1,
        S_FIN2,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_last, n_last;

    // Next state and datapath command.
    always_comb begin
        n_state    = r_state;
        n_last     = r_last;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_TAKE;
                    n_last   = i_key_end;
                    if (i_has_byte && i_status.block_full) begin
                        n_state = S_MIX1;
                    end else if (i_key_end) begin
                        n_state = S_FIN_SEL;
                    end
                end
            end
            S_MIX1: begin
                o_cmd.op = OP_MUL1;
                n_state  = S_MIX2;
            end
            S_MIX2: begin
                o_cmd.op = OP_MUL2;
                n_state  = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.op = OP_ROUND;
                n_state  = r_last ? S_FIN_SEL : S_IDLE;
            end
            S_FIN_SEL: begin
                if (i_status.tail_nonzero) begin
                    o_cmd.op = OP_TAIL1;
                    n_state  = S_TAIL2;
                end else begin
                    o_cmd.op = OP_PLAINXOR;
                    n_state  = S_FIN1;
                end
            end
            S_TAIL2: begin
                o_cmd.op = OP_MUL2;
                n_state  = S_TAIL3;
            end
            S_TAIL3: begin
                o_cmd.op = OP_TAILXOR;
                n_state  = S_FIN1;
            end
            S_FIN1: begin
                o_cmd.op = OP_FIN1;
                n_state  = S_FIN2;
            end
            S_FIN2: begin
                o_cmd.op = OP_FIN2;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

endmodule
